>>> hdl/hcb_pkg.sv
// Package for the code table builder: sizes, codes and the transaction types.
// No dependencies; every module of the block imports it.
`default_nettype none
package hcb_pkg;

    localparam int NUM_SYMBOLS  = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int FREQ_BITS    = 32;

    localparam int NODE_COUNT = 2 * NUM_SYMBOLS - 1;
    localparam int SYM_W      = $clog2(NUM_SYMBOLS);
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int SCAN_W     = SYM_W + 1;
    localparam int DEPTH_W    = SYM_W + 1;
    localparam int WEIGHT_W   = FREQ_BITS + SYM_W;
    localparam int CODE_W     = 30;
    localparam int LEN_W      = 5;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_CODE  = 2'd1;
    localparam logic [1:0] STAT_TOO_LONG = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  symbol;
        logic [31:0] freq;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        sym_out;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  code_length;
        logic [1:0]        status;
    } out_item_t;

    // One entry of the sorted node list.
    typedef struct packed {
        logic                valid;
        logic [WEIGHT_W-1:0] weight;
        logic [NODE_W-1:0]   idx;
    } node_item_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } chain_cmd_t;

endpackage
`default_nettype wire

>>> hdl/hcb_cell.sv
// One cell of the sorted node list: holds one node and trades it with its neighbours.
// Depends on hcb_pkg.
`default_nettype none
module hcb_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  hcb_pkg::chain_cmd_t cmd,
    input  hcb_pkg::node_item_t ins,
    input  hcb_pkg::node_item_t left_item,
    input  wire                 left_gt,
    input  hcb_pkg::node_item_t right_item,
    output hcb_pkg::node_item_t item,
    output logic                gt
);
    import hcb_pkg::*;

    node_item_t item_reg;
    node_item_t item_next;

    // An empty cell counts as heavier than anything, so a new node lands in it.
    assign gt   = !item_reg.valid || (item_reg.weight > ins.weight);
    assign item = item_reg;

    always_comb
    begin
        item_next = item_reg;
        if (cmd.clear)
        begin
            item_next.valid = 1'b0;
        end
        else if (cmd.pop)
        begin
            item_next = right_item;
        end
        else if (cmd.push && gt)
        begin
            if (left_gt)
            begin
                item_next = left_item;
            end
            else
            begin
                item_next       = ins;
                item_next.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end
endmodule
`default_nettype wire

>>> hdl/hcb_sort_chain.sv
// Row of list cells kept in ascending (weight, node index) order; the head is the minimum.
// Depends on hcb_pkg and hcb_cell.
`default_nettype none
module hcb_sort_chain (
    input  wire                 clk,
    input  wire                 rst_n,
    input  hcb_pkg::chain_cmd_t cmd,
    input  hcb_pkg::node_item_t ins,
    output hcb_pkg::node_item_t head
);
    import hcb_pkg::*;

    node_item_t items [NUM_SYMBOLS];
    logic       gts   [NUM_SYMBOLS];
    node_item_t empty_item;

    assign empty_item = '0;
    assign head       = items[0];

    for (genvar k = 0; k < NUM_SYMBOLS; k++)
    begin : g_cell
        node_item_t left_item;
        node_item_t right_item;
        logic       left_gt;

        if (k == 0)
        begin : g_first
            assign left_item = empty_item;
            assign left_gt   = 1'b0;
        end
        else
        begin : g_mid
            assign left_item = items[k-1];
            assign left_gt   = gts[k-1];
        end

        if (k == NUM_SYMBOLS - 1)
        begin : g_last
            assign right_item = empty_item;
        end
        else
        begin : g_inner
            assign right_item = items[k+1];
        end

        hcb_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .ins        (ins),
            .left_item  (left_item),
            .left_gt    (left_gt),
            .right_item (right_item),
            .item       (items[k]),
            .gt         (gts[k])
        );
    end
endmodule
`default_nettype wire

>>> hdl/huffman_code_table_builder.sv
// Top level of the code table builder: sequencer, node and code memories, result port.
// Depends on hcb_pkg and hcb_sort_chain.
//
// Usage. An input transaction (item: op, symbol, freq) is taken at a rising edge with
// start high and busy low. Every transaction gives one result on result, marked by done
// for exactly one cycle; the receiver cannot stall and must take it then.
// Load and read transactions: result in the cycle after acceptance, one per cycle.
// Build transaction: busy stays high while the block scans all symbol weights one per
// cycle, merges nodes through the sorted cell row (each merge a pop, a pop and an insert
// on the row), walks the tree (per internal node a read, then the left and the right
// child written in turn through the single write port of the walk memory) and, if no
// code is too long, writes the code table (a read and a write per leaf); its result
// comes in the same cycle in which busy falls.
// Reset clears all weights and the code table at once through valid bits; there is no
// clearing pass. Each build clears the code lengths during its scan.
`default_nettype none
module huffman_code_table_builder (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  hcb_pkg::in_item_t  item,
    output logic               done,
    output hcb_pkg::out_item_t result
);
    import hcb_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE       = 14'b00000000000001,
        ST_SCAN       = 14'b00000000000010,
        ST_DECIDE     = 14'b00000000000100,
        ST_POP_A      = 14'b00000000001000,
        ST_POP_B      = 14'b00000000010000,
        ST_PUSH       = 14'b00000000100000,
        ST_WALK_INIT  = 14'b00000001000000,
        ST_WALK_RD    = 14'b00000010000000,
        ST_WALK_L     = 14'b00000100000000,
        ST_WALK_R     = 14'b00001000000000,
        ST_WALK_CHECK = 14'b00010000000000,
        ST_EMIT_RD    = 14'b00100000000000,
        ST_EMIT_WR    = 14'b01000000000000,
        ST_FINISH     = 14'b10000000000000
    } state_t;

    state_t              state_reg,  state_next;
    logic [SCAN_W-1:0]   scan_reg,   scan_next;
    logic                pend_reg,   pend_next;
    logic [SYM_W-1:0]    psym_reg,   psym_next;
    logic [NODE_W-1:0]   n_reg,      n_next;
    logic [NODE_W-1:0]   cnt_reg,    cnt_next;
    logic [NODE_W-1:0]   idx_reg,    idx_next;
    logic [DEPTH_W-1:0]  maxd_reg,   maxd_next;
    logic [SYM_W-1:0]    first_reg,  first_next;
    node_item_t          a_reg,      a_next;
    node_item_t          b_reg,      b_next;
    logic [1:0]          bres_reg,   bres_next;
    logic                done_reg,   done_next;
    logic [1:0]          rop_reg,    rop_next;
    logic [7:0]          rsym_reg,   rsym_next;

    logic                accept;
    logic                sym_ok;
    logic [NODE_W:0]     two_n_m2;
    logic [NODE_W-1:0]   root;
    logic [NODE_W-1:0]   child;
    logic [DEPTH_W-1:0]  child_depth;

    chain_cmd_t          cmd;
    node_item_t          ins;
    node_item_t          head;

    // Symbol weights.
    logic [FREQ_BITS-1:0] sw_mem   [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] sw_valid_reg;
    logic                 sw_we;
    logic [FREQ_BITS-1:0] sw_rd_reg;

    // Code table.
    logic [CODE_W-1:0]    cs_mem   [NUM_SYMBOLS];
    logic [LEN_W-1:0]     ls_mem   [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] ls_valid_reg;
    logic                 ls_we;
    logic                 cs_we;
    logic [SYM_W-1:0]     tab_waddr;
    logic [CODE_W-1:0]    tab_wcode;
    logic [LEN_W-1:0]     tab_wlen;
    logic [CODE_W-1:0]    cs_rd_reg;
    logic [LEN_W-1:0]     ls_rd_reg;

    // Leaf labels, child links and walk results.
    logic [SYM_W-1:0]     lbl_mem  [NUM_SYMBOLS];
    logic                 lbl_we;
    logic [SYM_W-1:0]     lbl_rd_reg;
    logic [2*NODE_W-1:0]  link_mem [NODE_COUNT];
    logic                 link_we;
    logic [2*NODE_W-1:0]  link_rd_reg;
    logic [CODE_W-1:0]    wc_mem   [NODE_COUNT];
    logic [DEPTH_W-1:0]   wd_mem   [NODE_COUNT];
    logic                 w_we;
    logic [NODE_W-1:0]    w_waddr;
    logic [CODE_W-1:0]    w_wcode;
    logic [DEPTH_W-1:0]   w_wdepth;
    logic [CODE_W-1:0]    wc_rd_reg;
    logic [DEPTH_W-1:0]   wd_rd_reg;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign sym_ok   = ({1'b0, item.symbol} < 9'(NUM_SYMBOLS));
    assign two_n_m2 = {n_reg, 1'b0} - (NODE_W+1)'(2);
    assign root     = two_n_m2[NODE_W-1:0];
    assign done     = done_reg;

    hcb_sort_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ins   (ins),
        .head  (head)
    );

    always_comb
    begin
        state_next  = state_reg;
        scan_next   = scan_reg;
        pend_next   = pend_reg;
        psym_next   = psym_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        maxd_next   = maxd_reg;
        first_next  = first_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        bres_next   = bres_reg;
        done_next   = 1'b0;
        rop_next    = rop_reg;
        rsym_next   = rsym_reg;
        cmd         = '0;
        ins         = '0;
        sw_we       = 1'b0;
        ls_we       = 1'b0;
        cs_we       = 1'b0;
        tab_waddr   = '0;
        tab_wcode   = '0;
        tab_wlen    = '0;
        lbl_we      = 1'b0;
        link_we     = 1'b0;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wcode     = '0;
        w_wdepth    = '0;
        child       = link_rd_reg[2*NODE_W-1:NODE_W];
        child_depth = wd_rd_reg + DEPTH_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rop_next  = item.op;
                    rsym_next = item.symbol;
                    if (item.op == OP_BUILD)
                    begin
                        cmd.clear  = 1'b1;
                        n_next     = '0;
                        scan_next  = '0;
                        pend_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        sw_we     = (item.op == OP_LOAD) && sym_ok;
                        done_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                // The weight read last cycle becomes a leaf if it is nonzero.
                if (pend_reg && (sw_rd_reg != '0))
                begin
                    cmd.push   = 1'b1;
                    ins.valid  = 1'b1;
                    ins.weight = WEIGHT_W'(sw_rd_reg);
                    ins.idx    = n_reg;
                    lbl_we     = 1'b1;
                    if (n_reg == '0)
                    begin
                        first_next = psym_reg;
                    end
                    n_next = n_reg + NODE_W'(1);
                end
                if (scan_reg != SCAN_W'(NUM_SYMBOLS))
                begin
                    ls_we     = 1'b1;
                    tab_waddr = scan_reg[SYM_W-1:0];
                    pend_next = 1'b1;
                    psym_next = scan_reg[SYM_W-1:0];
                    scan_next = scan_reg + SCAN_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (n_reg == '0)
                begin
                    bres_next  = STAT_EMPTY;
                    state_next = ST_FINISH;
                end
                else if (n_reg == NODE_W'(1))
                begin
                    ls_we      = 1'b1;
                    cs_we      = 1'b1;
                    tab_waddr  = first_reg;
                    tab_wlen   = LEN_W'(1);
                    bres_next  = STAT_OK;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next   = n_reg;
                    state_next = ST_POP_A;
                end
            end
            ST_POP_A:
            begin
                cmd.pop    = 1'b1;
                a_next     = head;
                state_next = ST_POP_B;
            end
            ST_POP_B:
            begin
                cmd.pop    = 1'b1;
                b_next     = head;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                ins.valid  = 1'b1;
                ins.weight = a_reg.weight + b_reg.weight;
                ins.idx    = cnt_reg;
                link_we    = 1'b1;
                if (cnt_reg == root)
                begin
                    state_next = ST_WALK_INIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + NODE_W'(1);
                    state_next = ST_POP_A;
                end
            end
            ST_WALK_INIT:
            begin
                w_we       = 1'b1;
                w_waddr    = root;
                idx_next   = root;
                maxd_next  = '0;
                state_next = ST_WALK_RD;
            end
            ST_WALK_RD:
            begin
                state_next = ST_WALK_L;
            end
            ST_WALK_L:
            begin
                child      = link_rd_reg[2*NODE_W-1:NODE_W];
                w_we       = 1'b1;
                w_waddr    = child;
                w_wcode    = {wc_rd_reg[CODE_W-2:0], 1'b0};
                w_wdepth   = child_depth;
                if ((child < n_reg) && (child_depth > maxd_reg))
                begin
                    maxd_next = child_depth;
                end
                state_next = ST_WALK_R;
            end
            ST_WALK_R:
            begin
                child      = link_rd_reg[NODE_W-1:0];
                w_we       = 1'b1;
                w_waddr    = child;
                w_wcode    = {wc_rd_reg[CODE_W-2:0], 1'b1};
                w_wdepth   = child_depth;
                if ((child < n_reg) && (child_depth > maxd_reg))
                begin
                    maxd_next = child_depth;
                end
                if (idx_reg == n_reg)
                begin
                    state_next = ST_WALK_CHECK;
                end
                else
                begin
                    idx_next   = idx_reg - NODE_W'(1);
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_CHECK:
            begin
                if (32'(maxd_reg) > 32'(MAX_CODE_LEN - 2))
                begin
                    bres_next  = STAT_TOO_LONG;
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                ls_we     = 1'b1;
                cs_we     = 1'b1;
                tab_waddr = lbl_rd_reg;
                tab_wcode = wc_rd_reg;
                tab_wlen  = wd_rd_reg[LEN_W-1:0];
                if (idx_reg == n_reg - NODE_W'(1))
                begin
                    bres_next  = STAT_OK;
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + NODE_W'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            ST_FINISH:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            n_reg     <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            maxd_reg  <= '0;
            bres_reg  <= STAT_OK;
            done_reg  <= 1'b0;
            rop_reg   <= OP_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            n_reg     <= n_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            maxd_reg  <= maxd_next;
            bres_reg  <= bres_next;
            done_reg  <= done_next;
            rop_reg   <= rop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        psym_reg  <= psym_next;
        first_reg <= first_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        rsym_reg  <= rsym_next;
    end

    // Valid bits stand in for the reset value of the weight and length stores.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_valid_reg <= '0;
            ls_valid_reg <= '0;
        end
        else
        begin
            if (sw_we)
            begin
                sw_valid_reg[item.symbol[SYM_W-1:0]] <= 1'b1;
            end
            if (ls_we)
            begin
                ls_valid_reg[tab_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sw_we)
        begin
            sw_mem[item.symbol[SYM_W-1:0]] <= item.freq[FREQ_BITS-1:0];
        end
        sw_rd_reg <= sw_valid_reg[scan_reg[SYM_W-1:0]] ? sw_mem[scan_reg[SYM_W-1:0]] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ls_we)
        begin
            ls_mem[tab_waddr] <= tab_wlen;
        end
        if (cs_we)
        begin
            cs_mem[tab_waddr] <= tab_wcode;
        end
        ls_rd_reg <= ls_valid_reg[item.symbol[SYM_W-1:0]] ?
                     ls_mem[item.symbol[SYM_W-1:0]] : '0;
        cs_rd_reg <= cs_mem[item.symbol[SYM_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (lbl_we)
        begin
            lbl_mem[n_reg[SYM_W-1:0]] <= psym_reg;
        end
        lbl_rd_reg <= lbl_mem[idx_reg[SYM_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[cnt_reg] <= {a_reg.idx, b_reg.idx};
        end
        link_rd_reg <= link_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wc_mem[w_waddr] <= w_wcode;
            wd_mem[w_waddr] <= w_wdepth;
        end
        wc_rd_reg <= wc_mem[idx_reg];
        wd_rd_reg <= wd_mem[idx_reg];
    end

    always_comb
    begin
        result         = '0;
        result.sym_out = rsym_reg;
        case (rop_reg)
            OP_BUILD:
            begin
                result.status = bres_reg;
            end
            OP_READ:
            begin
                if (bres_reg != STAT_OK)
                begin
                    result.status = bres_reg;
                end
                else if (({1'b0, rsym_reg} < 9'(NUM_SYMBOLS)) && (ls_rd_reg != '0))
                begin
                    result.code        = cs_rd_reg;
                    result.code_length = ls_rd_reg;
                end
                else
                begin
                    result.status = STAT_NO_CODE;
                end
            end
            default:
            begin
                result.status = STAT_OK;
            end
        endcase
    end

    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.op == OP_BUILD) |=> busy)
        else $error("build transaction did not raise busy");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> done && (rop_reg == OP_BUILD))
        else $error("build finished without its result strobe");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_A) || (state_reg == ST_POP_B) |-> head.valid)
        else $error("node list empty during a merge");

    a_push_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> (cnt_reg <= root) && (cnt_reg >= n_reg))
        else $error("parent node index out of range");

endmodule
`default_nettype wire
